[sv/modular_exponentiation_core_defines.svh]
// Assertion macros shared by the modular exponentiation RTL.
// Included by the package users that carry concurrent checks; no other dependencies.
`ifndef MODULAR_EXPONENTIATION_CORE_DEFINES_SVH
`define MODULAR_EXPONENTIATION_CORE_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define MEXP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("mexp check failed");

// Next-cycle implication, disabled while in reset
`define MEXP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("mexp check failed");

`endif

[sv/mexp_pkg.sv]
// Shared types and constants for the modular exponentiation core.
// No dependencies; imported by mexp_modmul and modular_exponentiation_core.
`timescale 1ns / 1ps

package mexp_pkg;

	// Configuration register map
	localparam int CFG_IDX_W = 8;
	localparam logic [CFG_IDX_W-1:0] REG_MODULUS  = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_EXPONENT = 8'd1;

	// Fixed field widths on the ports
	localparam int FIELD_W = 32;

	// Status from the shared modular multiplier
	typedef struct packed {
		logic busy;
		logic done;
	} mm_stat_t;

	// Exponentiation sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RED_GO,
		ST_RED_WAIT,
		ST_SQ_GO,
		ST_SQ_WAIT,
		ST_MUL_GO,
		ST_MUL_WAIT,
		ST_DONE
	} state_t;

endpackage

[sv/mexp_modmul.sv]
// Bit-serial interleaved modular multiplier: product = (a * b) mod n.
// Scans a from its MSB, one bit per cycle; needs b < n and n != 0. Uses mexp_pkg.
`timescale 1ns / 1ps

module mexp_modmul #(
	parameter int WORD_WIDTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [WORD_WIDTH-1:0] a,
	input  logic [WORD_WIDTH-1:0] b,
	input  logic [WORD_WIDTH-1:0] n,
	output logic [WORD_WIDTH-1:0] product,
	output mexp_pkg::mm_stat_t    stat
);
	import mexp_pkg::*;

	`include "modular_exponentiation_core_defines.svh"

	localparam int CNT_W = $clog2(WORD_WIDTH + 1);

	logic [WORD_WIDTH-1:0] a_q;
	logic [WORD_WIDTH-1:0] b_q;
	logic [WORD_WIDTH-1:0] n_q;
	logic [WORD_WIDTH-1:0] r_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  busy_q;
	logic                  done_q;

	logic [WORD_WIDTH+1:0] sum;
	logic [WORD_WIDTH+1:0] n1;
	logic [WORD_WIDTH+1:0] n2;
	logic [WORD_WIDTH+1:0] d1;
	logic [WORD_WIDTH+1:0] d2;
	logic [WORD_WIDTH-1:0] r_next;
	logic                  ops_ok;

	// One step: r = 2r + bit*b, then bring back below n (sum < 3n)
	always_comb begin
		sum = {1'b0, r_q, 1'b0} + (a_q[WORD_WIDTH-1] ? {2'b00, b_q} : '0);
		n1  = {2'b00, n_q};
		n2  = {1'b0, n_q, 1'b0};
		d1  = sum - n1;
		d2  = sum - n2;
		if (sum >= n2) begin
			r_next = d2[WORD_WIDTH-1:0];
		end else if (sum >= n1) begin
			r_next = d1[WORD_WIDTH-1:0];
		end else begin
			r_next = sum[WORD_WIDTH-1:0];
		end
	end

	// Control: load on start, run WORD_WIDTH steps, pulse done
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(WORD_WIDTH);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Operands and partial remainder
	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			b_q <= b;
			n_q <= n;
			r_q <= '0;
		end else if (busy_q) begin
			a_q <= {a_q[WORD_WIDTH-2:0], 1'b0};
			r_q <= r_next;
		end
	end

	assign product   = r_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

	// Operands inside the multiplier's contract
	assign ops_ok = (n_q != '0) && (b_q < n_q);

	`MEXP_ASSERT_IMP(a_rem_below_mod, clk, arst_n, busy_q && ops_ok, r_q < n_q)
	`MEXP_ASSERT_NXT(a_done_single, clk, arst_n, done_q, !done_q)
	`MEXP_ASSERT_NXT(a_start_busy, clk, arst_n, start, busy_q && !done_q)

endmodule

[sv/modular_exponentiation_core.sv]
// Top level of the modular exponentiation core: stream ports, config registers,
// square-and-multiply sequencer. Uses mexp_pkg and mexp_modmul.
`timescale 1ns / 1ps

// Computes result = message^exponent mod modulus for each input transaction,
// MSB-first square-and-multiply over all WORD_WIDTH exponent bits on one shared
// bit-serial modular multiplier (one operand bit per cycle). A transaction runs
// one reduction of the message, then for each exponent bit a squaring and, for
// a one bit, a multiplication. A modulus of zero returns 0. s_axis_tready is
// high only between transactions; the finished result sits in an output
// register, so the next message may be taken while it waits. Config writes are
// taken every cycle and must only be issued while the core is idle. Bits above
// WORD_WIDTH of the message and both registers are ignored.
module modular_exponentiation_core #(
	parameter int WORD_WIDTH = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// input stream
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [mexp_pkg::FIELD_W-1:0]      s_axis_tdata,  // [31:0] message
	// output stream
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [mexp_pkg::FIELD_W-1:0]      m_axis_tdata,  // [31:0] result
	// configuration writes
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [mexp_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [mexp_pkg::FIELD_W-1:0]      cfg_data
);
	import mexp_pkg::*;

	`include "modular_exponentiation_core_defines.svh"

	localparam int BIT_W = $clog2(WORD_WIDTH);

	state_t                state_q;
	state_t                state_d;

	logic [WORD_WIDTH-1:0] mod_q;
	logic [WORD_WIDTH-1:0] exp_q;
	logic [WORD_WIDTH-1:0] msg_q;
	logic [WORD_WIDTH-1:0] n_q;
	logic [WORD_WIDTH-1:0] e_q;
	logic [WORD_WIDTH-1:0] one_q;
	logic [WORD_WIDTH-1:0] base_q;
	logic [WORD_WIDTH-1:0] acc_q;
	logic [BIT_W-1:0]      bit_q;
	logic [FIELD_W-1:0]    out_q;
	logic                  out_valid_q;

	logic                  in_xfer;
	logic                  out_free;
	logic                  mm_start;
	logic [WORD_WIDTH-1:0] mm_a;
	logic [WORD_WIDTH-1:0] mm_b;
	logic [WORD_WIDTH-1:0] mm_prod;
	mm_stat_t              mm_stat;
	logic                  ebit;
	logic                  last_bit;
	logic                  op_go;
	logic                  mul_phase;
	logic                  mm_waiting;

	assign in_xfer   = s_axis_tvalid && s_axis_tready;
	assign out_free  = !out_valid_q || m_axis_tready;
	assign ebit      = e_q[bit_q];
	assign last_bit  = (bit_q == '0);
	assign cfg_ready = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_q <= WORD_WIDTH'(1);
			exp_q <= WORD_WIDTH'(1);
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_MODULUS:  mod_q <= cfg_data[WORD_WIDTH-1:0];
				REG_EXPONENT: exp_q <= cfg_data[WORD_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	// Sequencer next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_axis_tvalid) begin
					state_d = (mod_q == '0) ? ST_DONE : ST_RED_GO;
				end
			end
			ST_RED_GO:   state_d = ST_RED_WAIT;
			ST_RED_WAIT: begin
				if (mm_stat.done) begin
					state_d = ST_SQ_GO;
				end
			end
			ST_SQ_GO:    state_d = ST_SQ_WAIT;
			ST_SQ_WAIT: begin
				if (mm_stat.done) begin
					if (ebit) begin
						state_d = ST_MUL_GO;
					end else if (last_bit) begin
						state_d = ST_DONE;
					end else begin
						state_d = ST_SQ_GO;
					end
				end
			end
			ST_MUL_GO:   state_d = ST_MUL_WAIT;
			ST_MUL_WAIT: begin
				if (mm_stat.done) begin
					state_d = last_bit ? ST_DONE : ST_SQ_GO;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default:     state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs: handshake and multiplier launch
	always_comb begin
		s_axis_tready = 1'b0;
		mm_start      = 1'b0;
		mm_a          = acc_q;
		mm_b          = acc_q;
		case (state_q)
			ST_IDLE:   s_axis_tready = 1'b1;
			ST_RED_GO: begin
				mm_start = 1'b1;
				mm_a     = msg_q;
				mm_b     = one_q;
			end
			ST_SQ_GO:  mm_start = 1'b1;
			ST_MUL_GO: begin
				mm_start = 1'b1;
				mm_b     = base_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Working registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_q <= '0;
		end else if (in_xfer) begin
			bit_q <= BIT_W'(WORD_WIDTH - 1);
		end else if (mm_stat.done && !last_bit &&
			((state_q == ST_MUL_WAIT) || ((state_q == ST_SQ_WAIT) && !ebit))) begin
			bit_q <= bit_q - BIT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			msg_q <= s_axis_tdata[WORD_WIDTH-1:0];
			n_q   <= mod_q;
			e_q   <= exp_q;
			one_q <= {{(WORD_WIDTH-1){1'b0}}, (mod_q != WORD_WIDTH'(1))};
			acc_q <= '0;
		end else if (mm_stat.done) begin
			if (state_q == ST_RED_WAIT) begin
				base_q <= mm_prod;
				acc_q  <= one_q;
			end else begin
				acc_q <= mm_prod;
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_DONE) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_DONE) && out_free) begin
			out_q <= FIELD_W'(acc_q);
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_q;

	// Shared multiplier
	mexp_modmul #(
		.WORD_WIDTH(WORD_WIDTH)
	) u_modmul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mm_start),
		.a       (mm_a),
		.b       (mm_b),
		.n       (n_q),
		.product (mm_prod),
		.stat    (mm_stat)
	);

	// Sequencer phase decodes for the checks below
	assign op_go      = (state_q == ST_SQ_GO) || (state_q == ST_MUL_GO);
	assign mul_phase  = (state_q == ST_MUL_GO) || (state_q == ST_MUL_WAIT);
	assign mm_waiting = (state_q == ST_RED_WAIT) || (state_q == ST_SQ_WAIT) ||
		(state_q == ST_MUL_WAIT);

	`MEXP_ASSERT_IMP(a_start_when_free, clk, arst_n, mm_start, !mm_stat.busy)
	`MEXP_ASSERT_IMP(a_acc_reduced, clk, arst_n, op_go, acc_q < n_q)
	`MEXP_ASSERT_IMP(a_base_reduced, clk, arst_n, mul_phase, base_q < n_q)
	`MEXP_ASSERT_IMP(a_done_only_waiting, clk, arst_n, mm_stat.done, mm_waiting)

endmodule
